// ===== hdl/ptt_pkg.sv =====
package ptt_pkg;

   // request kinds
   localparam logic [2:0] KIND_SCHEDULE = 3'd0;
   localparam logic [2:0] KIND_CANCEL   = 3'd1;
   localparam logic [2:0] KIND_TICK     = 3'd2;
   localparam logic [2:0] KIND_STOP     = 3'd3;
   localparam logic [2:0] KIND_START    = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_RUN   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // response id source
   localparam logic [1:0] SEL_ZERO   = 2'd0;
   localparam logic [1:0] SEL_ISSUED = 2'd1;
   localparam logic [1:0] SEL_ECHO   = 2'd2;
   localparam logic [1:0] SEL_FIRE   = 2'd3;

   localparam int REQ_BITS = 168;
   localparam int RSP_BITS = 48;

   typedef struct packed {
      logic [31:0] id;
      logic [47:0] expiry;
      logic [31:0] interval;
      logic        repeat_en;
      logic [1:0]  prio;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       idx_clr;
      logic       idx_inc;
      logic       prio_dec;
      logic       sch_write;
      logic       can_clear;
      logic       tick_eval;
      logic       stop;
      logic       start;
      logic       load;
      logic [1:0] sel;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_valid;
      logic [2:0] kind;
      logic       running;
      logic       slot_free;
      logic       id_match;
      logic       idx_last;
      logic       emit_hit;
      logic       none_due;
      logic       fire_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== hdl/priority_timer_table_core.sv =====
// Table of TIMER_SLOTS timers with priority dispatch. Each request beat carries a
// kind: schedule (returns the issued id, or not running / table full), cancel (echoes
// the id, ok or not found), tick (one beat per fired timer, highest priority first,
// lower slot first on ties, tlast on the final one; a single ok beat if none is due;
// not running when stopped), stop and start. Every response also reports the number
// of timers held afterwards. One request is handled at a time. Schedule scans the
// valid bits for the lowest free slot; cancel walks the slot memory through its single
// registered read port. Tick first reads every slot to mark the due ones, then runs
// the priority-ordered dispatch walk (up to four priority passes over the slots, one
// beat per fired timer). A response stalls the controller while rsp_tready holds it.
module priority_timer_table_core
   import ptt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // kind, expiry, interval, repeating, priority_req, cancel id, current_time
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // result_id, status, fired, fired_priority, pending_count
   output logic [RSP_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   ptt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ptt_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = cmd.req_ready;

endmodule

// ===== hdl/ptt_ctrl.sv =====
module ptt_ctrl
   import ptt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCH, S_CAN_RD, S_CAN_EV, S_TK_RD, S_TK_EV,
      S_TK_CHK, S_EM_CHK, S_EM_RD, S_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] st_ff, st_in;
   logic [1:0] sel_ff, sel_in;

   // state, pending response code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
         sel_ff   <= SEL_ZERO;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
         sel_ff   <= sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.idx_clr   = 1'b1;
            if (stat.req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            st_in    = ST_OK;
            sel_in   = SEL_ZERO;
            case (stat.kind)
               KIND_SCHEDULE: begin
                  if (!stat.running) st_in = ST_NOT_RUN;
                  else state_in = S_SCH;
               end
               KIND_CANCEL: state_in = S_CAN_RD;
               KIND_TICK: begin
                  if (!stat.running) st_in = ST_NOT_RUN;
                  else state_in = S_TK_RD;
               end
               KIND_STOP:  cmd.stop  = 1'b1;
               KIND_START: cmd.start = 1'b1;
               default: ;
            endcase
         end
         // lowest free slot
         S_SCH: begin
            if (stat.slot_free) begin
               cmd.sch_write = 1'b1;
               st_in    = ST_OK;
               sel_in   = SEL_ISSUED;
               state_in = S_RESP;
            end else if (stat.idx_last) begin
               st_in    = ST_FULL;
               sel_in   = SEL_ZERO;
               state_in = S_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_CAN_RD: state_in = S_CAN_EV;
         S_CAN_EV: begin
            sel_in = SEL_ECHO;
            if (stat.id_match) begin
               cmd.can_clear = 1'b1;
               st_in    = ST_OK;
               state_in = S_RESP;
            end else if (stat.idx_last) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CAN_RD;
            end
         end
         S_TK_RD: state_in = S_TK_EV;
         // mark due slots and re-arm or retire them
         S_TK_EV: begin
            cmd.tick_eval = 1'b1;
            if (stat.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_TK_CHK;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_TK_RD;
            end
         end
         S_TK_CHK: begin
            if (stat.none_due) begin
               st_in    = ST_OK;
               sel_in   = SEL_ZERO;
               state_in = S_RESP;
            end else begin
               state_in = S_EM_CHK;
            end
         end
         // walk priorities high to low, slots low to high
         S_EM_CHK: begin
            if (stat.emit_hit) begin
               state_in = S_EM_RD;
            end else if (stat.idx_last) begin
               cmd.idx_clr  = 1'b1;
               cmd.prio_dec = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_EM_RD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SEL_FIRE;
               if (stat.fire_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EM_CHK;
                  if (stat.idx_last) begin
                     cmd.idx_clr  = 1'b1;
                     cmd.prio_dec = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                  end
               end
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.load   = 1'b1;
               cmd.sel    = sel_ff;
               cmd.status = st_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hdl/ptt_datapath.sv =====
module ptt_datapath
   import ptt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                req_tvalid,
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   localparam int IW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   slot_type             mem [TIMER_SLOTS];
   slot_type             rd_ff;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] due_ff, due_in;
   logic [1:0]           dprio_ff [TIMER_SLOTS];
   logic [IW-1:0]        idx_ff, idx_in;
   logic [1:0]           prio_ff, prio_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        sent_ff, sent_in;
   logic [31:0]          last_id_ff, last_id_in;
   logic                 running_ff, running_in;
   logic [REQ_BITS-1:0]  req_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]  rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic [2:0]           r_kind;
   logic [47:0]          r_expiry;
   logic [31:0]          r_interval;
   logic                 r_repeat;
   logic [1:0]           r_prio;
   logic [31:0]          r_cancel_id;
   logic [47:0]          r_now;
   logic                 is_due;
   logic [48:0]          rearm_sum;
   logic                 mem_we;
   slot_type             mem_wd;
   logic [31:0]          out_id;
   logic [CW+4:0]        count_ext;

   assign accept      = req_tvalid && cmd.req_ready;
   assign r_kind      = req_ff[2:0];
   assign r_expiry    = req_ff[50:3];
   assign r_interval  = req_ff[82:51];
   assign r_repeat    = req_ff[83];
   assign r_prio      = req_ff[85:84];
   assign r_cancel_id = req_ff[117:86];
   assign r_now       = req_ff[165:118];

   assign is_due    = valid_ff[idx_ff] && (rd_ff.expiry <= r_now);
   assign rearm_sum = {1'b0, rd_ff.expiry} + {17'd0, rd_ff.interval};

   // slot memory write data
   always_comb begin
      mem_we = cmd.sch_write || (cmd.tick_eval && is_due && rd_ff.repeat_en);
      mem_wd = rd_ff;
      if (cmd.sch_write) begin
         mem_wd.id        = last_id_ff + 32'd1;
         mem_wd.expiry    = r_expiry;
         mem_wd.interval  = r_interval;
         mem_wd.repeat_en = r_repeat;
         mem_wd.prio      = r_prio;
      end else begin
         mem_wd.expiry = rearm_sum[48] ? '1 : rearm_sum[47:0];
      end
   end

   // slot memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= mem_wd;
      rd_ff <= mem[idx_ff];
   end

   // table control next values
   always_comb begin
      valid_in   = valid_ff;
      due_in     = due_ff;
      idx_in     = idx_ff;
      prio_in    = prio_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      sent_in    = sent_ff;
      last_id_in = last_id_ff;
      running_in = running_ff;
      if (accept) begin
         due_in   = '0;
         total_in = '0;
         sent_in  = '0;
         prio_in  = 2'd3;
      end
      if (cmd.idx_clr) idx_in = '0;
      if (cmd.idx_inc) idx_in = idx_ff + IW'(1);
      if (cmd.prio_dec) prio_in = prio_ff - 2'd1;
      if (cmd.sch_write) begin
         valid_in[idx_ff] = 1'b1;
         count_in   = count_ff + CW'(1);
         last_id_in = last_id_ff + 32'd1;
      end
      if (cmd.can_clear) begin
         valid_in[idx_ff] = 1'b0;
         count_in = count_ff - CW'(1);
      end
      if (cmd.tick_eval && is_due) begin
         due_in[idx_ff] = 1'b1;
         total_in = total_ff + CW'(1);
         if (!rd_ff.repeat_en) begin
            valid_in[idx_ff] = 1'b0;
            count_in = count_ff - CW'(1);
         end
      end
      if (cmd.stop) begin
         valid_in   = '0;
         count_in   = '0;
         running_in = 1'b0;
      end
      if (cmd.start) running_in = 1'b1;
      if (cmd.load && cmd.sel == SEL_FIRE) sent_in = sent_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         due_ff     <= '0;
         idx_ff     <= '0;
         prio_ff    <= 2'd3;
         count_ff   <= '0;
         total_ff   <= '0;
         sent_ff    <= '0;
         last_id_ff <= '0;
         running_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         due_ff     <= due_in;
         idx_ff     <= idx_in;
         prio_ff    <= prio_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         sent_ff    <= sent_in;
         last_id_ff <= last_id_in;
         running_ff <= running_in;
      end
   end

   // request capture and due priorities
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_tdata;
      if (cmd.tick_eval) dprio_ff[idx_ff] <= rd_ff.prio;
   end

   // result register
   always_comb begin
      case (cmd.sel)
         SEL_ISSUED: out_id = last_id_ff;
         SEL_ECHO:   out_id = r_cancel_id;
         SEL_FIRE:   out_id = rd_ff.id;
         default:    out_id = '0;
      endcase
      count_ext    = {5'd0, count_ff};
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (cmd.sel == SEL_FIRE) begin
            rsp_data_ff <= {6'd0, count_ext[4:0], rd_ff.prio, 1'b1, ST_OK, out_id};
            rsp_last_ff <= (sent_ff + CW'(1)) == total_ff;
         end else begin
            rsp_data_ff <= {6'd0, count_ext[4:0], 2'd0, 1'b0, cmd.status, out_id};
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // status to controller
   always_comb begin
      stat.req_valid = req_tvalid;
      stat.kind      = r_kind;
      stat.running   = running_ff;
      stat.slot_free = !valid_ff[idx_ff];
      stat.id_match  = valid_ff[idx_ff] && (rd_ff.id == r_cancel_id);
      stat.idx_last  = idx_ff == IW'(TIMER_SLOTS - 1);
      stat.emit_hit  = due_ff[idx_ff] && (dprio_ff[idx_ff] == prio_ff);
      stat.none_due  = total_ff == '0;
      stat.fire_last = (sent_ff + CW'(1)) == total_ff;
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ===== hdl/ptt_checker.sv =====
module ptt_checker
   import ptt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // fired results are always ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[33:32] == ST_OK)
      else $error("fired result with error status");

   // non-fired results stand alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[34] |-> rsp_tlast)
      else $error("single result without last");

endmodule

bind priority_timer_table_core ptt_checker u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
